[rtl/integer_literal_parser_assert.svh]
// Assertion macros used by the integer literal parser back end.
// Each macro names the assertion, the clock, the active-low reset, the
// antecedent, the consequent and the message text.
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ilp_pkg.sv]
// ----------------------------------------------------------------------------
// Integer literal parser package
// Types and constants shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package ilp_pkg;

	// Field widths.
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned POS_W   = 2;

	// Default depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// Literal modes.
	localparam logic [MODE_W-1:0] MODE_UDEC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SDEC = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BIN  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_HEX  = 2'd3;

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LOW_B = 8'h62;
	localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] HEX_LETTER_BASE = 8'd10;

	// Character positions within a literal; the position saturates.
	localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
	localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
	localparam logic [POS_W-1:0] POS_SAT    = 2'd3;

	// Digit limits for prefixed literals.
	localparam logic [COUNT_W-1:0] BIN_DIGIT_LIMIT = 7'd64;
	localparam logic [COUNT_W-1:0] HEX_DIGIT_LIMIT = 7'd16;
	localparam logic [COUNT_W-1:0] COUNT_SAT       = 7'd65;

	// Decimal limits, held at the width of acc*10 + digit.
	localparam int unsigned PROD_W = VALUE_W + 4;
	localparam logic [PROD_W-1:0] U64_LIMIT     = 68'h0_FFFF_FFFF_FFFF_FFFF;
	localparam logic [PROD_W-1:0] S64_MAG_LIMIT = 68'h0_7FFF_FFFF_FFFF_FFFF;

	// One classified character as it travels from front to back.
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic               last;
		logic [DIGIT_W-1:0] digit;
		logic               is_dec;
		logic               is_hex_letter;
		logic               is_under;
		logic               is_plus;
		logic               is_minus;
		logic               is_low_b;
		logic               is_low_x;
	} ilp_char_t;

endpackage

[rtl/ilp_front.sv]
// ----------------------------------------------------------------------------
// Integer literal parser front end
// Takes character transfers and classifies each byte for the back end.
// ----------------------------------------------------------------------------
module ilp_front
	import ilp_pkg::*;
(
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CHAR_W-1:0] s_tdata,  // [7:0] char_code
	input  logic [MODE_W-1:0] s_tuser,  // [1:0] mode
	input  logic              s_tlast,
	input  logic              q_full,
	output logic              push,
	output ilp_char_t         push_item
);

	logic [CHAR_W-1:0] dec_off;
	logic [CHAR_W-1:0] up_off;
	logic [CHAR_W-1:0] low_off;
	logic              is_up;
	logic              is_low;

	// A character is taken whenever the queue has room.
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// Character classes and digit values.
	assign dec_off = s_tdata - CH_ZERO;
	assign up_off  = s_tdata - CH_UP_A + HEX_LETTER_BASE;
	assign low_off = s_tdata - CH_LOW_A + HEX_LETTER_BASE;
	assign is_up   = (s_tdata >= CH_UP_A) && (s_tdata <= CH_UP_F);
	assign is_low  = (s_tdata >= CH_LOW_A) && (s_tdata <= CH_LOW_F);

	always_comb begin
		push_item.mode          = s_tuser;
		push_item.last          = s_tlast;
		push_item.is_dec        = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
		push_item.is_hex_letter = is_up || is_low;
		push_item.is_under      = (s_tdata == CH_UNDER);
		push_item.is_plus       = (s_tdata == CH_PLUS);
		push_item.is_minus      = (s_tdata == CH_MINUS);
		push_item.is_low_b      = (s_tdata == CH_LOW_B);
		push_item.is_low_x      = (s_tdata == CH_LOW_X);
		if (is_up) begin
			push_item.digit = up_off[DIGIT_W-1:0];
		end else if (is_low) begin
			push_item.digit = low_off[DIGIT_W-1:0];
		end else begin
			push_item.digit = dec_off[DIGIT_W-1:0];
		end
	end

endmodule

[rtl/ilp_queue.sv]
// ----------------------------------------------------------------------------
// Integer literal parser queue
// Short FIFO of classified characters between the front and back ends.
// ----------------------------------------------------------------------------
module ilp_queue
	import ilp_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ilp_char_t push_item,
	input  logic      pop,
	output logic      full,
	output logic      not_empty,
	output ilp_char_t head_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ilp_char_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/ilp_back.sv]
// ----------------------------------------------------------------------------
// Integer literal parser back end
// Runs the accumulator one character per cycle unless stalled; delivers the result.
// ----------------------------------------------------------------------------
`include "integer_literal_parser_assert.svh"

module ilp_back
	import ilp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  ilp_char_t          q_item,
	output logic               q_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,  // [63:0] value
	output logic [0:0]         m_tuser   // [0] ok
);

	// Literal state.
	logic [POS_W-1:0]   pos_q;
	logic [MODE_W-1:0]  mode_q;
	logic [VALUE_W-1:0] acc_q;
	logic               failed_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               neg_q;
	logic               sign_q;

	// Next literal state.
	logic [MODE_W-1:0]  cur_mode;
	logic [VALUE_W-1:0] n_acc;
	logic               n_failed;
	logic [COUNT_W-1:0] n_cnt;
	logic               n_neg;
	logic               n_sign;
	logic [POS_W-1:0]   n_pos;
	logic               lit_bad;

	// Step helpers.
	logic [PROD_W-1:0]  acc_wide;
	logic [PROD_W-1:0]  dec_prod;
	logic [PROD_W-1:0]  dec_limit;
	logic               dec_start;
	logic               is_hex;
	logic [COUNT_W-1:0] digit_limit;
	logic [COUNT_W-1:0] cnt_inc;

	// Result stage and output register.
	logic               res_valid_s1;
	logic [VALUE_W-1:0] res_acc_s1;
	logic               res_neg_s1;
	logic               res_bad_s1;
	logic               res_ready;
	logic               out_load;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_ok_q;

	// Flow control: a last character needs room in the result stage.
	assign out_load  = res_valid_s1 && (!out_valid_q || m_tready);
	assign res_ready = !res_valid_s1 || out_load;
	assign q_pop     = q_valid && (!q_item.last || res_ready);

	// Decimal step: acc*10 + digit with an exact range test.
	assign acc_wide    = {{(PROD_W - VALUE_W){1'b0}}, acc_q};
	assign dec_prod    = (acc_wide << 3) + (acc_wide << 1) + PROD_W'(q_item.digit);
	assign cur_mode    = (pos_q == POS_FIRST) ? q_item.mode : mode_q;
	assign dec_limit   = (cur_mode == MODE_SDEC) ? S64_MAG_LIMIT : U64_LIMIT;
	assign dec_start   = (pos_q == (sign_q ? POS_SECOND : POS_FIRST));
	assign is_hex      = (cur_mode == MODE_HEX);
	assign digit_limit = is_hex ? HEX_DIGIT_LIMIT : BIN_DIGIT_LIMIT;
	assign cnt_inc     = (cnt_q < COUNT_SAT) ? cnt_q + 1'b1 : cnt_q;
	assign n_pos       = (pos_q == POS_SAT) ? POS_SAT : pos_q + 1'b1;

	// Character step; an earlier failure freezes the literal.
	always_comb begin
		n_acc    = acc_q;
		n_failed = failed_q;
		n_cnt    = cnt_q;
		n_neg    = neg_q;
		n_sign   = sign_q;
		if (!failed_q) begin
			unique case (cur_mode)
				MODE_UDEC, MODE_SDEC: begin
					if ((cur_mode == MODE_SDEC) && (pos_q == POS_FIRST) &&
					    (q_item.is_plus || q_item.is_minus)) begin
						n_sign = 1'b1;
						n_neg  = q_item.is_minus;
					end else if (q_item.is_under) begin
						n_failed = dec_start;
					end else if (!q_item.is_dec) begin
						n_failed = 1'b1;
					end else if (dec_prod > dec_limit) begin
						n_failed = 1'b1;
					end else begin
						n_acc = dec_prod[VALUE_W-1:0];
					end
				end
				MODE_BIN, MODE_HEX: begin
					if (pos_q == POS_FIRST) begin
						n_failed = !(q_item.is_dec && (q_item.digit == '0));
					end else if (pos_q == POS_SECOND) begin
						n_failed = !(is_hex ? q_item.is_low_x : q_item.is_low_b);
					end else if (q_item.is_under) begin
						n_failed = 1'b0;
					end else if (!(q_item.is_dec || (is_hex && q_item.is_hex_letter)) ||
					             (!is_hex && (q_item.digit > 4'd1))) begin
						n_failed = 1'b1;
					end else begin
						n_acc = is_hex ? {acc_q[VALUE_W-5:0], q_item.digit}
						               : {acc_q[VALUE_W-2:0], q_item.digit[0]};
						n_cnt = cnt_inc;
						n_failed = (cnt_inc > digit_limit);
					end
				end
			endcase
		end
	end

	// Checks made when the literal ends.
	assign lit_bad = n_failed ||
	                 ((cur_mode == MODE_SDEC) && n_sign && (pos_q == POS_FIRST)) ||
	                 (((cur_mode == MODE_BIN) || (cur_mode == MODE_HEX)) && !pos_q[1]);

	// Literal state update; a last character clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_FIRST;
			mode_q   <= MODE_UDEC;
			acc_q    <= '0;
			failed_q <= 1'b0;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
			sign_q   <= 1'b0;
		end else if (q_pop) begin
			if (q_item.last) begin
				pos_q    <= POS_FIRST;
				mode_q   <= MODE_UDEC;
				acc_q    <= '0;
				failed_q <= 1'b0;
				cnt_q    <= '0;
				neg_q    <= 1'b0;
				sign_q   <= 1'b0;
			end else begin
				pos_q    <= n_pos;
				mode_q   <= cur_mode;
				acc_q    <= n_acc;
				failed_q <= n_failed;
				cnt_q    <= n_cnt;
				neg_q    <= n_neg;
				sign_q   <= n_sign;
			end
		end
	end

	// Valid flags of the result stage and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop && q_item.last) begin
				res_valid_s1 <= 1'b1;
			end else if (out_load) begin
				res_valid_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; the sign is applied in its own stage.
	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			res_acc_s1 <= n_acc;
			res_neg_s1 <= (cur_mode == MODE_SDEC) && n_neg;
			res_bad_s1 <= lit_bad;
		end
		if (out_load) begin
			if (res_bad_s1) begin
				out_value_q <= '0;
			end else if (res_neg_s1) begin
				out_value_q <= '0 - res_acc_s1;
			end else begin
				out_value_q <= res_acc_s1;
			end
			out_ok_q <= !res_bad_s1;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_value_q;
	assign m_tuser[0] = out_ok_q;

	// A failed literal always reports a zero value.
	`ILP_ASSERT_IMPL(a_fail_value_zero, clk, arst_n, out_valid_q && !out_ok_q, out_value_q == '0, "failed result carries a nonzero value")
	// The literal state is clear after its last character.
	`ILP_ASSERT_NEXT(a_clear_after_last, clk, arst_n, q_pop && q_item.last, (pos_q == POS_FIRST) && !failed_q && (cnt_q == '0), "literal state not cleared after last character")
	// A waiting result is not dropped while the output register is full.
	`ILP_ASSERT_NEXT(a_result_held, clk, arst_n, res_valid_s1 && !out_load, res_valid_s1, "pending result lost")

endmodule

[rtl/integer_literal_parser.sv]
// Throughput: one character per cycle while the sink keeps up; a stalled sink holds
// back only the last character of a literal, and the queue then fills.
// Result path: the last character of a literal loads the result stage, then the output
// register driving m_tvalid (accumulator step, then sign stage); the transfer can follow at once.
// The rate is set by the accumulator, which takes one character per cycle unless stalled.
// Reset: arst_n clears all control and literal state at once; no clearing pass.
// ----------------------------------------------------------------------------
// Integer literal parser
// Parses decimal, signed decimal, binary and hex literals one character at a
// time and returns the value with an ok flag on the last character.
// ----------------------------------------------------------------------------
module integer_literal_parser
	import ilp_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] char_code
	input  logic [MODE_W-1:0]  s_tuser,   // [1:0] mode
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,   // [63:0] value
	output logic [0:0]         m_tuser    // [0] ok
);

	logic      push;
	ilp_char_t push_item;
	logic      q_full;
	logic      q_not_empty;
	logic      q_pop;
	ilp_char_t head_item;

	// Front end: accept and classify characters.
	ilp_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Queue between front and back.
	ilp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	// Back end: accumulate and deliver results.
	ilp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_not_empty),
		.q_item   (head_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
